// ===== sv/tcbh_pkg.sv =====
// ----------------------------------------------------------------------------
// tcbh_pkg
// Types and constants shared by the trip computer button handler modules.
// ----------------------------------------------------------------------------
package tcbh_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BUTTONS_ENABLE  = 3'd0,
        REG_TOUCH_ENABLE    = 3'd1,
        REG_MODE_MAX        = 3'd2,
        REG_BOOT_LOCKOUT    = 3'd3,
        REG_SHORT_LIMIT     = 3'd4,
        REG_LONG_LIMIT      = 3'd5,
        REG_VERY_LONG_LIMIT = 3'd6
    } reg_idx_t;

    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the registers
    localparam logic [2:0]  MODE_MAX_RST        = 3'd5;
    localparam logic [15:0] BOOT_LOCKOUT_RST    = 16'd3000;
    localparam logic [15:0] SHORT_LIMIT_RST     = 16'd1000;
    localparam logic [15:0] LONG_LIMIT_RST      = 16'd3000;
    localparam logic [15:0] VERY_LONG_LIMIT_RST = 16'd7000;

    // Bit positions in the recorded pin levels
    localparam int unsigned LV_MODE  = 0;
    localparam int unsigned LV_BANK  = 1;
    localparam int unsigned LV_CLEAR = 2;
    localparam int unsigned LV_TOUCH = 3;

    // Buttons idle high, touch idle low
    localparam logic [3:0]  LEVELS_RST = 4'b0111;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic mode_level;
        logic bank_level;
        logic clear_level;
        logic touch_level;
    } in_t;

    typedef struct packed {
        logic [2:0] display_mode;
        logic       bank;
        logic       uptime_shown;
        logic       clear_request;
        logic [2:0] clear_mode;
        logic       clear_bank;
        logic       mode_changed;
    } out_t;

    typedef struct packed {
        logic        buttons_enable;
        logic        touch_enable;
        logic [2:0]  mode_max;
        logic [15:0] boot_lockout_ticks;
        logic [15:0] short_limit;
        logic [15:0] long_limit;
        logic [15:0] very_long_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0] boot_count;
        logic [3:0]  last_levels;
        logic        touch_held;
        logic [15:0] press_ticks;
        logic [2:0]  mode;
        logic        bank;
        logic        uptime;
    } state_t;

    localparam state_t STATE_RST = '{
        boot_count:  16'd0,
        last_levels: LEVELS_RST,
        touch_held:  1'b0,
        press_ticks: 16'd0,
        mode:        3'd0,
        bank:        1'b0,
        uptime:      1'b0
    };

endpackage

// ===== sv/tcbh_cfg.sv =====
// ----------------------------------------------------------------------------
// tcbh_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module tcbh_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_index,
    input  logic [tcbh_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output tcbh_pkg::cfg_t               cfg
);
    import tcbh_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_wr_index))
                REG_BUTTONS_ENABLE:  cfg_next.buttons_enable     = cfg_wr_data[0];
                REG_TOUCH_ENABLE:    cfg_next.touch_enable       = cfg_wr_data[0];
                REG_MODE_MAX:        cfg_next.mode_max           = cfg_wr_data[2:0];
                REG_BOOT_LOCKOUT:    cfg_next.boot_lockout_ticks = cfg_wr_data;
                REG_SHORT_LIMIT:     cfg_next.short_limit        = cfg_wr_data;
                REG_LONG_LIMIT:      cfg_next.long_limit         = cfg_wr_data;
                REG_VERY_LONG_LIMIT: cfg_next.very_long_limit    = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.buttons_enable     <= 1'b1;
            cfg_reg.touch_enable       <= 1'b1;
            cfg_reg.mode_max           <= MODE_MAX_RST;
            cfg_reg.boot_lockout_ticks <= BOOT_LOCKOUT_RST;
            cfg_reg.short_limit        <= SHORT_LIMIT_RST;
            cfg_reg.long_limit         <= LONG_LIMIT_RST;
            cfg_reg.very_long_limit    <= VERY_LONG_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tcbh_step.sv =====
// ----------------------------------------------------------------------------
// tcbh_step
// One tick of button handling: next state and result from the sampled levels.
// ----------------------------------------------------------------------------
module tcbh_step (
    input  tcbh_pkg::cfg_t   cfg,
    input  tcbh_pkg::state_t state_cur,
    input  tcbh_pkg::in_t    levels,
    output tcbh_pkg::state_t state_next,
    output tcbh_pkg::out_t   result
);
    import tcbh_pkg::*;

    // Mode advance, wrapping to zero past the maximum
    function automatic logic [2:0] mode_advance(input logic [2:0] m, input logic [2:0] mx);
        logic [3:0] n;
        n = {1'b0, m} + 4'd1;
        if (n > {1'b0, mx}) begin
            return 3'd0;
        end
        return n[2:0];
    endfunction

    logic [3:0]  lv;
    logic [15:0] press_inc;
    logic        locked;
    logic        mode_fall;
    logic        clear_fall;
    logic        touch_rise;
    logic        held_a;
    logic [15:0] press_a;
    logic        release_now;
    logic [2:0]  mode_a;
    logic        bank_a;
    logic        req;
    logic        changed;
    logic [2:0]  req_mode;
    logic        req_bank;
    state_t      st;

    assign lv = {levels.touch_level, levels.clear_level, levels.bank_level, levels.mode_level};

    // Press counter runs whenever a press is held, lockout or not
    assign press_inc = (state_cur.touch_held && state_cur.press_ticks != COUNT_MAX)
                     ? state_cur.press_ticks + 16'd1 : state_cur.press_ticks;

    assign locked     = state_cur.boot_count < cfg.boot_lockout_ticks;
    assign mode_fall  = !lv[LV_MODE]  &&  state_cur.last_levels[LV_MODE];
    assign clear_fall = !lv[LV_CLEAR] &&  state_cur.last_levels[LV_CLEAR];
    assign touch_rise =  lv[LV_TOUCH] && !state_cur.last_levels[LV_TOUCH];

    always_comb begin
        st          = state_cur;
        st.press_ticks = press_inc;
        req         = 1'b0;
        changed     = 1'b0;
        req_mode    = 3'd0;
        req_bank    = 1'b0;
        mode_a      = state_cur.mode;
        bank_a      = state_cur.bank;
        held_a      = state_cur.touch_held;
        press_a     = press_inc;
        release_now = 1'b0;

        if (locked) begin
            if (state_cur.boot_count != COUNT_MAX) begin
                st.boot_count = state_cur.boot_count + 16'd1;
            end
        end else begin
            // Buttons: mode edge, bank level, clear edge
            if (cfg.buttons_enable) begin
                if (mode_fall) begin
                    mode_a  = mode_advance(state_cur.mode, cfg.mode_max);
                    changed = 1'b1;
                end
                bank_a = lv[LV_BANK];
                if (clear_fall) begin
                    req      = 1'b1;
                    req_mode = mode_a;
                    req_bank = bank_a;
                end
            end
            // Touch: start timing on press, sort on release
            if (cfg.touch_enable) begin
                if (touch_rise) begin
                    held_a  = 1'b1;
                    press_a = 16'd0;
                end
                release_now = !lv[LV_TOUCH] && held_a;
                if (release_now) begin
                    held_a = 1'b0;
                    if (press_a < cfg.short_limit) begin
                        mode_a  = mode_advance(mode_a, cfg.mode_max);
                        changed = 1'b1;
                    end else if (press_a < cfg.long_limit) begin
                        bank_a = ~bank_a;
                    end else if (press_a < cfg.very_long_limit) begin
                        req      = 1'b1;
                        req_mode = mode_a;
                        req_bank = bank_a;
                    end else begin
                        st.uptime = ~state_cur.uptime;
                    end
                end
            end
            st.mode        = mode_a;
            st.bank        = bank_a;
            st.touch_held  = held_a;
            st.press_ticks = press_a;
        end
        st.last_levels = lv;
    end

    assign state_next = st;

    assign result.display_mode  = st.mode;
    assign result.bank          = st.bank;
    assign result.uptime_shown  = st.uptime;
    assign result.clear_request = req;
    assign result.clear_mode    = req_mode;
    assign result.clear_bank    = req_bank;
    assign result.mode_changed  = changed;

endmodule

// ===== sv/trip_computer_button_handler.sv =====
// Trip computer button handler. Takes one beat of four pin levels per tick and
// returns one result beat for each. An input beat is held in an input register,
// worked through the combinational tick logic and caught in a result register,
// from which the result beat is presented. The block sustains one beat per
// cycle while the result side keeps taking them; the rate is set by that one
// pass through the tick logic. Reset needs no clearing pass. The user must see
// that configuration registers are written only while idle; it is not enforced.
// ----------------------------------------------------------------------------
// trip_computer_button_handler
// Top level: input register, tick logic, handler state and result register.
// ----------------------------------------------------------------------------
module trip_computer_button_handler (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tcbh_pkg::in_t                    s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tcbh_pkg::out_t                   m_data,
    input  logic                             cfg_wr_en,
    input  logic [2:0]                       cfg_wr_index,
    input  logic [tcbh_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import tcbh_pkg::*;

    cfg_t   cfg;
    state_t state_reg;
    state_t state_next;
    out_t   result;

    logic   s1_valid_reg;
    in_t    s1_data_reg;
    logic   m_valid_reg;
    out_t   m_data_reg;

    logic   out_free;
    logic   fire;

    tcbh_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    tcbh_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .levels     (s1_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Handshake: a beat moves on when the result register is free or draining
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;

    // Control and handler state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= STATE_RST;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg <= s_data;
        end
        if (fire) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !s1_valid_reg)
        else $error("pipeline not empty after reset");

    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input beat lost while result side stalled");

    a_lockout_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && state_reg.boot_count < cfg.boot_lockout_ticks
        |=> !m_data_reg.clear_request && !m_data_reg.mode_changed)
        else $error("action taken during boot lockout");

    a_mode_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_data_reg.display_mode == state_reg.mode
                 && m_data_reg.bank == state_reg.bank)
        else $error("result disagrees with handler state");

endmodule
